// File: rtl/core/wcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_pkg
// Shared types, codes and helpers of the wildcard string matcher.
// ----------------------------------------------------------------------------
package wcm_pkg;

  // field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 6;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 7;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TEXT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd2;

  // pattern symbols
  localparam logic [BYTE_W-1:0] SYM_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] SYM_ANY  = 8'h3F;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic matched;
  } result_t;

  // fold lower-case ascii letters onto upper case
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] f;
    f = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      f = c - 8'h20;
    end
    return f;
  endfunction

endpackage

// File: rtl/core/wcm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_if
// Valid/ready channels of the matcher: input word and result word.
// ----------------------------------------------------------------------------
interface wcm_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcm_pkg::ACT_W-1:0]   action;
  logic [wcm_pkg::IDX_W-1:0]   pattern_index;
  logic [wcm_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output action, output pattern_index,
                  output data_byte, input ready);
  modport sink   (input valid, input action, input pattern_index,
                  input data_byte, output ready);
endinterface

interface wcm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// File: rtl/core/wildcard_string_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_string_matcher
// Streams text words against a stored '*' / '?' pattern, case-insensitive.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per handshake: a pattern byte write (action 0),
//   a text byte (action 1) or end of text (action 2). out_ch carries one
//   matched bit for every end-of-text word; other words give no result.
//   cfg_we / cfg_wdata set the pattern length; write it only while idle.
// Sequencing:
//   a pattern write, and any text byte after a decision, leaves the sequencer
//   idle. Otherwise a text byte reads the store (single read port, registered
//   read data) and stays in ST_SYM while it walks over stars that are not the
//   last pattern byte; an empty pattern needs no read. End of text goes
//   to ST_EMIT when decided, rewound or at the end of the pattern, else it
//   first scans in ST_SCAN; the result then sits in the output register.
// Reset:
//   rst_n clears the match state, the length and the output valid bit; the
//   pattern store is not cleared and must be written before use.
// Stall:
//   while out_ch is stalled the result is held; further pattern and text
//   words are still taken, a second end of text waits until the slot frees.
// ----------------------------------------------------------------------------
module wildcard_string_matcher #(
  parameter int PATTERN_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wcm_in_if.sink                      in_ch,
  wcm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [wcm_pkg::POS_W-1:0]   cfg_wdata
);

  localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

  logic [wcm_pkg::POS_W-1:0]   cfg_len_r;
  logic [wcm_pkg::POS_W-1:0]   len_act;
  logic                        mem_wr_en;
  logic [ADDR_W-1:0]           mem_wr_addr;
  logic [wcm_pkg::BYTE_W-1:0]  mem_wr_data;
  logic                        mem_rd_en;
  logic [ADDR_W-1:0]           mem_rd_addr;
  logic [wcm_pkg::BYTE_W-1:0]  mem_rd_data;
  wcm_pkg::result_t            res;
  logic                        res_ready;
  logic                        out_valid_r;
  logic                        out_matched_r;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= '0;
    end else if (cfg_we) begin
      cfg_len_r <= cfg_wdata;
    end
  end

  // lengths beyond the store are clipped to its depth
  assign len_act = (32'(cfg_len_r) > PATTERN_DEPTH) ? wcm_pkg::POS_W'(PATTERN_DEPTH)
                                                    : cfg_len_r;

  wcm_pattern_mem #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  wcm_match_ctrl #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_action        (in_ch.action),
    .in_pattern_index (in_ch.pattern_index),
    .in_data_byte     (in_ch.data_byte),
    .len              (len_act),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data),
    .res              (res),
    .res_ready        (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_matched_r <= res.matched;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = out_matched_r;

  // a pending result blocks new words
  a_res_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ch.ready)
    else $error("input word accepted while a result is pending");

  // end of text always takes the sequencer out of idle
  a_end_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action == wcm_pkg::ACT_END) |=> !in_ch.ready)
    else $error("end of text did not start a result");

  // a result refused by the output register is offered again
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.matched)))
    else $error("result dropped while output register full");

endmodule

// File: rtl/core/wcm_pattern_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_pattern_mem
// Pattern store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wcm_pattern_mem #(
  parameter int PATTERN_DEPTH = 64,
  parameter int ADDR_W        = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [wcm_pkg::BYTE_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [wcm_pkg::BYTE_W-1:0]  rd_data
);

  logic [wcm_pkg::BYTE_W-1:0] mem [PATTERN_DEPTH];
  logic [wcm_pkg::BYTE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/wcm_match_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_match_ctrl
// Match sequencer: walks the pattern store for each text word and scans the
// tail of the pattern on end of text.
// ----------------------------------------------------------------------------
module wcm_match_ctrl #(
  parameter int PATTERN_DEPTH = 64,
  parameter int ADDR_W        = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input word
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wcm_pkg::ACT_W-1:0]   in_action,
  input  logic [wcm_pkg::IDX_W-1:0]   in_pattern_index,
  input  logic [wcm_pkg::BYTE_W-1:0]  in_data_byte,
  // active pattern length
  input  logic [wcm_pkg::POS_W-1:0]   len,
  // pattern store
  output logic                        mem_wr_en,
  output logic [ADDR_W-1:0]           mem_wr_addr,
  output logic [wcm_pkg::BYTE_W-1:0]  mem_wr_data,
  output logic                        mem_rd_en,
  output logic [ADDR_W-1:0]           mem_rd_addr,
  input  logic [wcm_pkg::BYTE_W-1:0]  mem_rd_data,
  // result
  output wcm_pkg::result_t            res,
  input  logic                        res_ready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM,
    ST_LAST,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [wcm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [wcm_pkg::POS_W-1:0]   resume_r, resume_nxt;
  logic                        star_r, star_nxt;
  logic                        skip_r, skip_nxt;
  logic                        dec_r, dec_nxt;
  logic                        decval_r, decval_nxt;
  logic                        match_r, match_nxt;
  logic [wcm_pkg::BYTE_W-1:0]  byte_r, byte_nxt;

  logic                        fire;
  logic [wcm_pkg::POS_W-1:0]   pos_inc;
  logic                        sym_lit_eq;

  assign fire       = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign pos_inc    = pos_r + 1'b1;
  assign sym_lit_eq = (wcm_pkg::fold_case(mem_rd_data) == wcm_pkg::fold_case(byte_r));

  // pattern writes go straight to the store
  assign mem_wr_en   = fire && (in_action == wcm_pkg::ACT_WRITE) &&
                       (32'(in_pattern_index) < PATTERN_DEPTH);
  assign mem_wr_addr = ADDR_W'(in_pattern_index);
  assign mem_wr_data = in_data_byte;

  assign res.valid   = (state_r == ST_EMIT);
  assign res.matched = match_r;

  // next state and store reads
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    resume_nxt  = resume_r;
    star_nxt    = star_r;
    skip_nxt    = skip_r;
    dec_nxt     = dec_r;
    decval_nxt  = decval_r;
    match_nxt   = match_r;
    byte_nxt    = byte_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ADDR_W'(pos_r);

    unique case (state_r)
      ST_IDLE: begin
        if (fire && in_action == wcm_pkg::ACT_TEXT && !dec_r) begin
          byte_nxt = in_data_byte;
          skip_nxt = 1'b0;
          if (len == '0) begin
            dec_nxt    = 1'b1;
            decval_nxt = 1'b0;
          end else if (pos_r >= len) begin
            // end of pattern: look at the last symbol
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(len - 1'b1);
            state_nxt   = ST_LAST;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = ST_SYM;
          end
        end else if (fire && in_action == wcm_pkg::ACT_END) begin
          if (dec_r) begin
            match_nxt = decval_r;
            state_nxt = ST_EMIT;
          end else if (skip_r) begin
            match_nxt = 1'b0;
            state_nxt = ST_EMIT;
          end else if (pos_r >= len) begin
            match_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SYM: begin
        priority if (mem_rd_data == wcm_pkg::SYM_STAR) begin
          pos_nxt    = pos_inc;
          star_nxt   = 1'b1;
          resume_nxt = pos_inc;
          if (pos_inc >= len) begin
            // this star is the last pattern byte
            dec_nxt    = 1'b1;
            decval_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(pos_inc);
          end
        end else if (mem_rd_data == wcm_pkg::SYM_ANY || sym_lit_eq) begin
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end else if (star_r) begin
          skip_nxt  = 1'b1;
          pos_nxt   = resume_r;
          state_nxt = ST_IDLE;
        end else begin
          dec_nxt    = 1'b1;
          decval_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      ST_LAST: begin
        dec_nxt    = 1'b1;
        decval_nxt = (mem_rd_data == wcm_pkg::SYM_STAR);
        state_nxt  = ST_IDLE;
      end

      ST_SCAN: begin
        if (mem_rd_data != wcm_pkg::SYM_STAR) begin
          match_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else if (pos_inc >= len) begin
          match_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          pos_nxt     = pos_inc;
          mem_rd_en   = 1'b1;
          mem_rd_addr = ADDR_W'(pos_inc);
        end
      end

      ST_EMIT: begin
        if (res_ready) begin
          // result taken: match state back to its reset values
          pos_nxt    = '0;
          resume_nxt = '0;
          star_nxt   = 1'b0;
          skip_nxt   = 1'b0;
          dec_nxt    = 1'b0;
          decval_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      resume_r <= '0;
      star_r   <= 1'b0;
      skip_r   <= 1'b0;
      dec_r    <= 1'b0;
      decval_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      resume_r <= resume_nxt;
      star_r   <= star_nxt;
      skip_r   <= skip_nxt;
      dec_r    <= dec_nxt;
      decval_r <= decval_nxt;
      match_r  <= match_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule

// File: verif/tb_wildcard_string_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_string_matcher
// Self-checking bench for the streaming wildcard matcher.
// A scoreboard class keeps its own copy of the pattern store, the length and
// the match state, works out the matched bit for every end-of-text word it
// sees accepted, and compares it in order with the result channel. A short
// directed part covers the corner cases. After it come random phases, each
// with its own pattern length and pattern, fed mostly with texts built to fit
// the pattern, some of them spoilt, and with stray pattern writes and spare
// action codes mixed in. Both channels stall at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_wildcard_string_matcher;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned RAND_WORDS  = 780;
  localparam int unsigned CALM_FROM   = 680;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [wcm_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

  // expected matched bits, worked out from a private copy of the block state
  class match_scoreboard;
    logic [wcm_pkg::BYTE_W-1:0] store [DEPTH];
    logic [wcm_pkg::POS_W-1:0]  length_reg;
    int unsigned       pos;
    int unsigned       resume_pos;
    bit                star_hit;
    bit                dropped;
    bit                settled;
    bit                verdict;
    bit                verdict_q [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       hits;

    function new();
      foreach (store[i]) store[i] = '0;
      length_reg = '0;
      errors = 0;
      checked = 0;
      hits = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      pos = 0;
      resume_pos = 0;
      star_hit = 1'b0;
      dropped = 1'b0;
      settled = 1'b0;
      verdict = 1'b0;
    endfunction

    function logic [wcm_pkg::BYTE_W-1:0] upcase(logic [wcm_pkg::BYTE_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function int unsigned live_length();
      return (length_reg > DEPTH) ? DEPTH : int'(length_reg);
    endfunction

    function void set_length(logic [wcm_pkg::POS_W-1:0] v);
      length_reg = v;
    endfunction

    // one text byte: pass stars, then consume, rewind or decide
    function void walk_byte(logic [wcm_pkg::BYTE_W-1:0] c);
      int unsigned n;
      logic [wcm_pkg::BYTE_W-1:0] s;
      n = live_length();
      if (settled) return;
      dropped = 1'b0;
      while (pos < n && store[pos] == wcm_pkg::SYM_STAR) begin
        pos++;
        star_hit = 1'b1;
        resume_pos = pos;
      end
      if (pos >= n) begin
        settled = 1'b1;
        verdict = (n > 0) && (store[n-1] == wcm_pkg::SYM_STAR);
        return;
      end
      s = store[pos];
      if (s == wcm_pkg::SYM_ANY || upcase(s) == upcase(c)) begin
        pos++;
      end else if (star_hit) begin
        dropped = 1'b1;
        pos = resume_pos;
      end else begin
        settled = 1'b1;
        verdict = 1'b0;
      end
    endfunction

    // end of text: latched decision, else only stars may remain
    function bit close_text();
      int unsigned n;
      bit m;
      n = live_length();
      if (settled) begin
        m = verdict;
      end else if (dropped) begin
        m = 1'b0;
      end else begin
        m = 1'b1;
        for (int unsigned p = pos; p < n; p++) begin
          if (store[p] != wcm_pkg::SYM_STAR) m = 1'b0;
        end
      end
      clear_walk();
      return m;
    endfunction

    function void note_word(logic [wcm_pkg::ACT_W-1:0] act, logic [wcm_pkg::IDX_W-1:0] idx,
                            logic [wcm_pkg::BYTE_W-1:0] b);
      case (act)
        wcm_pkg::ACT_WRITE: store[idx] = b;
        wcm_pkg::ACT_TEXT:  walk_byte(b);
        wcm_pkg::ACT_END:   verdict_q.push_back(close_text());
        default: ;
      endcase
    endfunction

    function void check_result(logic m);
      bit e;
      checked++;
      if (m === 1'b1) hits++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing outstanding: matched=%b", m);
        return;
      end
      e = verdict_q.pop_front();
      if (m !== e) begin
        errors++;
        if (errors <= 10)
          $display("matched mismatch on result %0d: expected %b got %b", checked, e, m);
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [wcm_pkg::POS_W-1:0]    cfg_wdata = '0;

  wcm_in_if  in_if ();
  wcm_out_if out_if ();

  match_scoreboard              sb = new();
  logic [wcm_pkg::BYTE_W-1:0]   pat_buf [DEPTH];
  logic [wcm_pkg::BYTE_W-1:0]   text_q [$];
  int unsigned         words_sent = 0;
  int unsigned         cycle_count = 0;
  bit                  calm = 1'b0;
  bit                  hold_now = 1'b0;
  bit                  held = 1'b0;

  wildcard_string_matcher #(.PATTERN_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("tb_wildcard_string_matcher: errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.matched);
  end

  // result side: random stalls, one long hold-off, none once calm
  initial begin : result_sink
    int unsigned n;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_now && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        n = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 14);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic bit is_letter(logic [wcm_pkg::BYTE_W-1:0] c);
    return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
  endfunction

  function automatic logic [wcm_pkg::BYTE_W-1:0] rand_letter();
    logic [wcm_pkg::BYTE_W-1:0] c;
    c = 8'h41 + 8'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 1) c = c | 8'h20;
    return c;
  endfunction

  function automatic logic [wcm_pkg::BYTE_W-1:0] rand_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2: return wcm_pkg::SYM_STAR;
      3, 4:    return wcm_pkg::SYM_ANY;
      9:       return 8'($urandom_range(0, 255));
      default: return rand_letter();
    endcase
  endfunction

  // one word on the input channel, with an occasional gap before it
  task automatic send_word(logic [wcm_pkg::ACT_W-1:0] act, logic [wcm_pkg::IDX_W-1:0] idx,
                           logic [wcm_pkg::BYTE_W-1:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.pattern_index <= idx;
    in_if.data_byte     <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_word(act, idx, b);
    if (act != ACT_SPARE) words_sent++;
  endtask

  // wait for every result, then let a trailing walk settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic start_phase(logic [wcm_pkg::POS_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    sb.set_length(len);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_pattern(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_word(wcm_pkg::ACT_WRITE, wcm_pkg::IDX_W'(i), pat_buf[i]);
  endtask

  task automatic load_string(string s);
    for (int i = 0; i < s.len(); i++) pat_buf[i] = s[i];
    load_pattern(s.len());
  endtask

  // stray pattern writes and spare codes between text bytes
  task automatic add_noise();
    int unsigned k;
    logic [wcm_pkg::IDX_W-1:0] idx;
    logic [wcm_pkg::BYTE_W-1:0] b;
    k = $urandom_range(0, 99);
    idx = wcm_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
    if (k < 3) begin
      b = rand_symbol();
      pat_buf[idx] = b;
      send_word(wcm_pkg::ACT_WRITE, idx, b);
    end else if (k < 5) begin
      send_word(ACT_SPARE, idx, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_text(bit noisy);
    foreach (text_q[i]) begin
      if (noisy) add_noise();
      send_word(wcm_pkg::ACT_TEXT, wcm_pkg::IDX_W'($urandom_range(0, DEPTH - 1)), text_q[i]);
    end
    send_word(wcm_pkg::ACT_END, wcm_pkg::IDX_W'($urandom_range(0, DEPTH - 1)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic run_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text(1'b0);
  endtask

  // text that fits the first n pattern symbols, sometimes spoilt
  task automatic make_text(int unsigned n);
    logic [wcm_pkg::BYTE_W-1:0] s;
    text_q.delete();
    for (int unsigned i = 0; i < n; i++) begin
      s = pat_buf[i];
      if (s == wcm_pkg::SYM_STAR) begin
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_letter());
      end else if (s == wcm_pkg::SYM_ANY) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (is_letter(s) && $urandom_range(0, 1) == 1) begin
        text_q.push_back(s ^ 8'h20);
      end else begin
        text_q.push_back(s);
      end
    end
    case ($urandom_range(0, 8))
      0: if (text_q.size() != 0) text_q[$urandom_range(0, text_q.size() - 1)] = rand_letter();
      1: if (text_q.size() != 0) void'(text_q.pop_back());
      2: text_q.push_back(rand_letter());
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned base;
    int unsigned phase_no;
    int unsigned k;
    logic [wcm_pkg::POS_W-1:0] len;
    in_if.valid         <= 1'b0;
    in_if.action        <= wcm_pkg::ACT_WRITE;
    in_if.pattern_index <= '0;
    in_if.data_byte     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern: bare end of text, then a zero byte against nothing
    run_text("");
    text_q = {8'h00};
    send_text(1'b0);

    // star rewind, '?' and case folding
    start_phase(7'd5);
    load_string("h*L?o");
    run_text("HeLlo");
    run_text("hl");
    run_text("hLqz");

    // early decisions, later bytes ignored
    start_phase(7'd3);
    load_string("ab*");
    run_text("abQz");
    run_text("xb");

    // zero and all-ones bytes, top index, spare code
    start_phase(7'd2);
    pat_buf[0] = 8'h00;
    pat_buf[1] = 8'hFF;
    load_pattern(2);
    send_word(wcm_pkg::ACT_WRITE, 6'd63, 8'hFF);
    send_word(ACT_SPARE, 6'd63, 8'hFF);
    text_q = {8'h00, 8'hFF};
    send_text(1'b0);

    // length above the store depth over a store full of stars
    start_phase(7'd127);
    for (int i = 0; i < DEPTH; i++) pat_buf[i] = wcm_pkg::SYM_STAR;
    load_pattern(DEPTH);
    run_text("x");

    // random phases: new length and pattern, then several texts
    base = words_sent;
    phase_no = 0;
    while (words_sent - base < RAND_WORDS) begin
      calm = (words_sent - base >= CALM_FROM);
      k = $urandom_range(0, 99);
      if (k < 5)       len = '0;
      else if (k < 80) len = wcm_pkg::POS_W'($urandom_range(1, 8));
      else if (k < 90) len = wcm_pkg::POS_W'($urandom_range(9, 63));
      else if (k < 95) len = wcm_pkg::POS_W'(DEPTH);
      else             len = wcm_pkg::POS_W'($urandom_range(65, 127));
      n = (len > DEPTH) ? DEPTH : int'(len);
      start_phase(len);
      for (int unsigned i = 0; i < n; i++) pat_buf[i] = rand_symbol();
      load_pattern(n);
      // long hold-off on the result side while texts keep coming
      if (phase_no == 0) begin
        hold_now = 1'b1;
        wait (held);
      end
      repeat ($urandom_range(3, 6)) begin
        make_text(n);
        send_text(1'b1);
      end
      phase_no++;
    end

    drain();
    $display("%0d words over %0d random phases, %0d results checked (%0d matched), %0d errors",
             words_sent, phase_no, sb.checked, sb.hits, sb.errors);
    $display("lengths 0 to 127, stray pattern writes mid-text, one %0d-cycle output hold-off",
             LONG_HOLD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_wildcard_string_matcher: clean");
    end else begin
      $display("tb_wildcard_string_matcher: errors");
    end
    $finish;
  end

endmodule
